// File: rtl/graphic_equalizer_bandpass_bank_macros.svh
// assertion macros used by the equalizer top level
`ifndef GRAPHIC_EQUALIZER_BANDPASS_BANK_MACROS_SVH
`define GRAPHIC_EQUALIZER_BANDPASS_BANK_MACROS_SVH

// property checked on every rising clock edge outside reset
`define GEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define GEQ_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) else $error(msg);

`endif

// File: rtl/geq_pkg.sv
// shared constants, types and saturation helpers of the equalizer
package geq_pkg;

  localparam int BANDS    = 10;
  localparam int CHANNELS = 8;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int VAL_W    = 32;
  localparam int MA_W     = 28;              // serial operand: coefficient or gain
  localparam int MB_W     = 33;              // parallel operand: value or difference
  localparam int MP_W     = MA_W + MB_W;
  localparam int BSUM_W   = 60;
  localparam int ACC_W    = 62;

  localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int CADDR_W = $clog2(BANDS * 4);
  localparam int HADDR_W = $clog2(2 * CHANNELS * BANDS);
  localparam int XADDR_W = $clog2(2 * CHANNELS);

  typedef enum logic [1:0] {
    REG_IN_FACTOR   = 2'd0,
    REG_PREAMP_GAIN = 2'd1,
    REG_SECOND_PASS = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEL_ALPHA = 2'd0,
    SEL_BETA  = 2'd1,
    SEL_GAMMA = 2'd2,
    SEL_GAIN  = 2'd3
  } coef_sel_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) return 32'sh7fff_ffff;
    else if (v < 64'shffff_ffff_8000_0000) return 32'sh8000_0000;
    else return v[VAL_W-1:0];
  endfunction

  // returns {clipped, value}
  function automatic logic [SAMPLE_W:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return {1'b1, 16'h7fff};
    else if (v < -64'sd32768) return {1'b1, 16'h8000};
    else return {1'b0, v[SAMPLE_W-1:0]};
  endfunction

endpackage

// File: rtl/geq_ram.sv
// single port write, registered read memory with per-entry valid bits
module geq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rv_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rv_q <= vld_q[raddr_i];
      end
    end
  end

  // entries never written read as zero
  assign rdata_o = rv_q ? rd_q : '0;
endmodule

// File: rtl/geq_mul.sv
// bit-serial signed shift-add multiplier, one bit of the serial operand per cycle
module geq_mul
  import geq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [MA_W-1:0] a_i,
  input  logic signed [MB_W-1:0] b_i,
  output mul_stat_t              stat_o,
  output logic signed [MP_W-1:0] p_o
);
  localparam int CNT_W = $clog2(MA_W);

  logic [MA_W-1:0]  a_q, lo_q;
  logic [MB_W-1:0]  b_q;
  logic [MB_W:0]    hi_q, bx, addend, sum;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, last;

  assign last   = (cnt_q == CNT_W'(MA_W - 1));
  assign bx     = {b_q[MB_W-1], b_q};
  // the top bit of a two's complement operand weighs negative
  assign addend = a_q[0] ? (last ? (~bx + 1'b1) : bx) : '0;
  assign sum    = hi_q + addend;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      a_q  <= {1'b0, a_q[MA_W-1:1]};
      hi_q <= {sum[MB_W], sum[MB_W:1]};
      lo_q <= {sum[0], lo_q[MA_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign p_o = {hi_q[MB_W-1:0], lo_q};
endmodule

// File: rtl/graphic_equalizer_bandpass_bank.sv
// top level: sequencer of the graphic equalizer band bank
// usage
//   input channel (in_valid_i / in_ready_o): one word per rising edge with both high.
//   cmd_i = 1 writes one band coefficient or band gain, no result;
//   cmd_i = 0 filters one sample of channel_i and gives one result word.
//   samples of a channel at or beyond the channel count are dropped.
//   output channel (out_valid_o / out_ready_i): the result is held in an output
//   register until taken, and the next input word is accepted meanwhile.
// sequence
//   one shared bit-serial multiplier does every product; a band product takes a
//   coefficient read, a start and the bit steps of the multiplier. a pass reads the
//   input history, takes four products per band and one with the input factor. a
//   two-pass result adds a second pass plus the squared gain; the next word is
//   taken once the result is in the output register.
// reset
//   coefficients and histories read as zero through per-entry valid bits of the
//   memories; config registers take their default values.
// stall
//   a stalled receiver holds the result; the sequencer holds the next result
//   until the output register is free.
`include "graphic_equalizer_bandpass_bank_macros.svh"

module graphic_equalizer_bandpass_bank
  import geq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [2:0]                 channel_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_in_block_i,
  input  logic [3:0]                 band_index_i,
  input  logic [1:0]                 coef_select_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  // result words
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o,
  output logic [2:0]                 out_channel_o,
  output logic                       last_in_block_res_o,
  output logic                       saturated_o
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_XRD  = 13'b0000000000010,
    S_XWT  = 13'b0000000000100,
    S_CRD  = 13'b0000000001000,
    S_CGO  = 13'b0000000010000,
    S_CMW  = 13'b0000000100000,
    S_FGO  = 13'b0000001000000,
    S_FMW  = 13'b0000010000000,
    S_PGO  = 13'b0000100000000,
    S_PMW  = 13'b0001000000000,
    S_GGO  = 13'b0010000000000,
    S_GMW  = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_e;

  state_e state_q;

  // config registers
  logic signed [COEF_W-1:0] in_factor_q, preamp_q;
  logic                     second_q;
  reg_idx_e                 widx, ridx;

  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[3:2]);
  assign ridx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_factor_q <= 24'sd262144;
      preamp_q    <= 24'sd1048576;
      second_q    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_IN_FACTOR:   in_factor_q <= pwdata[COEF_W-1:0];
        REG_PREAMP_GAIN: preamp_q    <= pwdata[COEF_W-1:0];
        REG_SECOND_PASS: second_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_IN_FACTOR:   prdata = {8'h00, in_factor_q};
      REG_PREAMP_GAIN: prdata = {8'h00, preamp_q};
      REG_SECOND_PASS: prdata = {31'h0, second_q};
      default:         prdata = '0;
    endcase
  end

  // sequencer registers
  logic [2:0]               ch_q;
  logic                     last_q, pass_q;
  logic signed [VAL_W-1:0]  x_q, y_q, tot_q, bsum_q;
  logic signed [VAL_W:0]    diff_q;
  logic [BAND_W-1:0]        j_q;
  coef_sel_e                sel_q;
  logic [HADDR_W-1:0]       hb_q;
  logic signed [BSUM_W-1:0] ysum_q, ysum_nx;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [MA_W-1:0]   gain_q;
  logic signed [SAMPLE_W-1:0] res_q;
  logic                     res_sat_q;

  // output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic [2:0]                 out_ch_q;
  logic                       out_last_q, out_sat_q;

  logic accept, ch_ok;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign ch_ok      = (32'(channel_i) < CHANNELS);

  // memories
  logic                  c_we, c_re;
  logic [CADDR_W-1:0]    c_waddr, c_raddr;
  logic [COEF_W-1:0]     c_rd;
  logic                  h_we, h_re;
  logic [HADDR_W-1:0]    h_addr;
  logic [2*VAL_W-1:0]    h_rd;
  logic                  x_we, x_re;
  logic [XADDR_W-1:0]    x_addr;
  logic [2*VAL_W-1:0]    x_rd;

  assign c_we    = accept && cmd_i && (32'(band_index_i) < BANDS);
  assign c_waddr = CADDR_W'({band_index_i, coef_select_i});
  assign c_re    = (state_q == S_CRD);
  assign c_raddr = CADDR_W'({j_q, sel_q});

  assign h_addr = (pass_q ? HADDR_W'(CHANNELS * BANDS) : '0) + hb_q + HADDR_W'(j_q);
  assign h_re   = (state_q == S_CRD) && (sel_q == SEL_ALPHA);

  assign x_addr = (pass_q ? XADDR_W'(CHANNELS) : '0) + XADDR_W'(ch_q);
  assign x_re   = (state_q == S_XRD);
  assign x_we   = (state_q == S_XWT);

  // multiplier
  logic                   mul_start;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  mul_stat_t              mul_st;
  logic signed [MP_W-1:0] mul_p;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_CGO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'($signed(c_rd));
        case (sel_q)
          SEL_ALPHA: mul_b = diff_q;
          SEL_BETA:  mul_b = MB_W'($signed(h_rd[VAL_W-1:0]));
          SEL_GAMMA: mul_b = MB_W'($signed(h_rd[2*VAL_W-1:VAL_W]));
          default:   mul_b = MB_W'(y_q);
        endcase
      end
      S_FGO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(in_factor_q);
        mul_b     = MB_W'(x_q);
      end
      S_PGO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(preamp_q);
        mul_b     = MB_W'(preamp_q);
      end
      S_GGO: begin
        mul_start = 1'b1;
        mul_a     = gain_q;
        mul_b     = MB_W'(tot_q);
      end
      default: ;
    endcase
  end

  // band value: alpha*diff - beta*y2 + gamma*y1
  assign ysum_nx = ysum_q + BSUM_W'(mul_p);
  logic signed [VAL_W-1:0] y_new, tot_new;
  logic [SAMPLE_W:0]       r16;
  assign y_new   = sat32(64'(ysum_nx >>> 20));
  assign tot_new = sat32(64'(mul_p >>> 20) + 64'(bsum_q));
  assign r16     = sat16(64'(mul_p >>> 29));

  assign h_we = (state_q == S_CMW) && mul_st.done && (sel_q == SEL_GAMMA);

  logic res_free;
  assign res_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= channel_i;
      last_q <= last_in_block_i;
      x_q    <= {{(VAL_W-SAMPLE_W-9){sample_i[SAMPLE_W-1]}}, sample_i, 9'b0};
      hb_q   <= HADDR_W'(channel_i) * HADDR_W'(BANDS);
    end
    case (state_q)
      S_XWT: begin
        diff_q <= (VAL_W+1)'(x_q) - (VAL_W+1)'($signed(x_rd[VAL_W-1:0]));
        acc_q  <= '0;
      end
      S_CMW: begin
        if (mul_st.done) begin
          case (sel_q)
            SEL_ALPHA: ysum_q <= BSUM_W'(mul_p);
            SEL_BETA:  ysum_q <= ysum_q - BSUM_W'(mul_p);
            SEL_GAMMA: y_q    <= y_new;
            default:   acc_q  <= acc_q + ACC_W'(mul_p);
          endcase
        end
      end
      S_FGO: bsum_q <= sat32(64'(acc_q >>> 20));
      S_FMW: begin
        if (mul_st.done) begin
          tot_q <= tot_new;
          x_q   <= tot_new;
          gain_q <= MA_W'(preamp_q);
        end
      end
      S_PMW: begin
        if (mul_st.done) begin
          gain_q <= MA_W'(mul_p >>> 20);
        end
      end
      S_GMW: begin
        if (mul_st.done) begin
          res_q     <= r16[SAMPLE_W-1:0];
          res_sat_q <= r16[SAMPLE_W];
        end
      end
      default: ;
    endcase
    if ((state_q == S_OUT) && res_free) begin
      out_sample_q <= res_q;
      out_ch_q     <= ch_q;
      out_last_q   <= last_q;
      out_sat_q    <= res_sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      j_q         <= '0;
      sel_q       <= SEL_ALPHA;
      out_valid_q <= 1'b0;
    end else begin
      // load a new result word or drop the one taken
      if ((state_q == S_OUT) && res_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && !cmd_i && ch_ok) begin
            pass_q  <= 1'b0;
            state_q <= S_XRD;
          end
        end
        S_XRD: state_q <= S_XWT;
        S_XWT: begin
          j_q     <= '0;
          sel_q   <= SEL_ALPHA;
          state_q <= S_CRD;
        end
        S_CRD: state_q <= S_CGO;
        S_CGO: state_q <= S_CMW;
        S_CMW: begin
          if (mul_st.done) begin
            if (sel_q != SEL_GAIN) begin
              sel_q   <= coef_sel_e'(sel_q + 2'd1);
              state_q <= S_CRD;
            end else if (j_q == BAND_W'(BANDS - 1)) begin
              state_q <= S_FGO;
            end else begin
              j_q     <= j_q + 1'b1;
              sel_q   <= SEL_ALPHA;
              state_q <= S_CRD;
            end
          end
        end
        S_FGO: state_q <= S_FMW;
        S_FMW: begin
          if (mul_st.done) begin
            if (!pass_q && second_q) begin
              pass_q  <= 1'b1;
              state_q <= S_XRD;
            end else if (pass_q) begin
              state_q <= S_PGO;
            end else begin
              state_q <= S_GGO;
            end
          end
        end
        S_PGO: state_q <= S_PMW;
        S_PMW: if (mul_st.done) state_q <= S_GGO;
        S_GGO: state_q <= S_GMW;
        S_GMW: if (mul_st.done) state_q <= S_OUT;
        S_OUT: begin
          if (res_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  geq_ram #(.DEPTH(BANDS * 4), .WIDTH(COEF_W)) u_coef (
    .clk_i, .rst_ni,
    .we_i(c_we), .waddr_i(c_waddr), .wdata_i(coef_value_i),
    .re_i(c_re), .raddr_i(c_raddr), .rdata_o(c_rd)
  );

  // band history word: {y[n-1], y[n-2]}
  geq_ram #(.DEPTH(2 * CHANNELS * BANDS), .WIDTH(2 * VAL_W)) u_hist (
    .clk_i, .rst_ni,
    .we_i(h_we), .waddr_i(h_addr), .wdata_i({y_new, h_rd[2*VAL_W-1:VAL_W]}),
    .re_i(h_re), .raddr_i(h_addr), .rdata_o(h_rd)
  );

  // input history word: {x[n-1], x[n-2]}
  geq_ram #(.DEPTH(2 * CHANNELS), .WIDTH(2 * VAL_W)) u_xhist (
    .clk_i, .rst_ni,
    .we_i(x_we), .waddr_i(x_addr), .wdata_i({x_q, x_rd[2*VAL_W-1:VAL_W]}),
    .re_i(x_re), .raddr_i(x_addr), .rdata_o(x_rd)
  );

  geq_mul u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .stat_o(mul_st), .p_o(mul_p)
  );

  assign out_valid_o         = out_valid_q;
  assign out_sample_o        = out_sample_q;
  assign out_channel_o       = out_ch_q;
  assign last_in_block_res_o = out_last_q;
  assign saturated_o         = out_sat_q;

  `GEQ_ASSERT(a_mul_no_restart, mul_start |-> !mul_st.busy, "multiplier started while busy")
  `GEQ_ASSERT_NEXT(a_sample_starts, accept && !cmd_i && ch_ok, state_q == S_XRD, "sample not started")
  `GEQ_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == S_OUT), "stray result word")
endmodule
